// File: rtl/nsf_pkg.sv
`default_nettype none

package nsf_pkg;

	// Sentence limits. A byte count or argument count that reaches these aborts.
	localparam logic [7:0] MaxLen  = 8'd128;
	localparam logic [5:0] MaxArgs = 6'd32;

	// Framing characters.
	localparam logic [7:0] ChDollar = 8'h24;
	localparam logic [7:0] ChStar   = 8'h2A;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChLf     = 8'h0A;

	// Type words, first character in the low byte.
	localparam logic [39:0] WordGpgga = 40'h41_47_47_50_47;
	localparam logic [39:0] WordGpgsv = 40'h56_53_47_50_47;

	// Number of type characters that are stored.
	localparam logic [2:0] TypeChars   = 3'd5;
	localparam logic [2:0] TypeTooLong = 3'd6;

	// Event codes.
	localparam logic EvDone  = 1'b0;
	localparam logic EvError = 1'b1;

	// Sentence type codes.
	localparam logic [1:0] KindOther = 2'd0;
	localparam logic [1:0] KindGga   = 2'd1;
	localparam logic [1:0] KindGsv   = 2'd2;

	typedef enum logic [2:0] {
		PhIdle = 3'd0,
		PhType = 3'd1,
		PhArgs = 3'd2,
		PhCsum = 3'd3,
		PhCr   = 3'd4
	} nsf_phase_t;

	typedef struct packed {
		logic        event_kind;
		logic [1:0]  sentence_kind;
		logic [5:0]  field_count;
		logic [7:0]  byte_count;
		logic [31:0] sentences_seen;
		logic [31:0] framing_errors_seen;
	} nsf_event_t;

	typedef struct packed {
		logic       fire;
		nsf_event_t evt;
	} nsf_step_t;

endpackage

`default_nettype wire

// File: rtl/nsf_byte_if.sv
`default_nettype none

interface nsf_byte_if;

	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

// File: rtl/nsf_event_if.sv
`default_nettype none

interface nsf_event_if;

	logic        valid;
	logic        ready;
	logic        event_kind;
	logic [1:0]  sentence_kind;
	logic [5:0]  field_count;
	logic [7:0]  byte_count;
	logic [31:0] sentences_seen;
	logic [31:0] framing_errors_seen;

	modport source (
		output valid, output event_kind, output sentence_kind, output field_count,
		output byte_count, output sentences_seen, output framing_errors_seen,
		input ready
	);
	modport sink (
		input valid, input event_kind, input sentence_kind, input field_count,
		input byte_count, input sentences_seen, input framing_errors_seen,
		output ready
	);

endinterface

`default_nettype wire

// File: rtl/nsf_core.sv
`default_nettype none

// Framing state machine: takes one byte per step and updates the sentence state.
module nsf_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire logic [7:0]     rx_byte,
	output nsf_pkg::nsf_step_t  res
);

	nsf_pkg::nsf_phase_t phase_q, phase_d;
	logic [7:0]  bytes_q, bytes_d, bytes_inc;
	logic [5:0]  fields_q, fields_d, fields_inc;
	logic [39:0] chars_q, chars_d;
	logic [2:0]  tlen_q, tlen_d;
	logic [31:0] sent_q, sent_d;
	logic [31:0] errs_q, errs_d;
	logic        ovf_len, ovf_args, fail, done;
	logic [1:0]  kind;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
			((c >= 8'h61) && (c <= 8'h66));
	endfunction

	// Next state and the result of this byte.
	always_comb begin
		phase_d    = phase_q;
		bytes_d    = bytes_q;
		fields_d   = fields_q;
		chars_d    = chars_q;
		tlen_d     = tlen_q;
		sent_d     = sent_q;
		errs_d     = errs_q;
		fail       = 1'b0;
		done       = 1'b0;
		kind       = nsf_pkg::KindOther;
		bytes_inc  = bytes_q + 8'd1;
		fields_inc = fields_q + 6'd1;
		ovf_len    = bytes_inc >= nsf_pkg::MaxLen;
		ovf_args   = fields_inc >= nsf_pkg::MaxArgs;

		unique case (phase_q)
			nsf_pkg::PhType: begin
				if (is_alnum(rx_byte)) begin
					bytes_d = bytes_inc;
					if (ovf_len) begin
						fail = 1'b1;
					end else if (tlen_q < nsf_pkg::TypeChars) begin
						chars_d[{tlen_q, 3'b000} +: 8] = rx_byte;
						tlen_d = tlen_q + 3'd1;
					end else begin
						tlen_d = nsf_pkg::TypeTooLong;
					end
				end else if (rx_byte == nsf_pkg::ChComma) begin
					bytes_d = bytes_inc;
					if (ovf_len) begin
						fail = 1'b1;
					end else begin
						phase_d = nsf_pkg::PhArgs;
					end
				end else begin
					fail = 1'b1;
				end
			end
			nsf_pkg::PhArgs: begin
				if (is_alnum(rx_byte) || (rx_byte == nsf_pkg::ChDot) ||
					(rx_byte == nsf_pkg::ChMinus) || (rx_byte == nsf_pkg::ChPlus)) begin
					bytes_d = bytes_inc;
					fail    = ovf_len;
				end else if ((rx_byte == nsf_pkg::ChComma) ||
					(rx_byte == nsf_pkg::ChStar)) begin
					bytes_d = bytes_inc;
					if (ovf_len) begin
						fail = 1'b1;
					end else begin
						fields_d = fields_inc;
						if (ovf_args) begin
							fail = 1'b1;
						end else if (rx_byte == nsf_pkg::ChStar) begin
							phase_d = nsf_pkg::PhCsum;
						end
					end
				end else begin
					fail = 1'b1;
				end
			end
			nsf_pkg::PhCsum: begin
				if (is_hex(rx_byte) || (rx_byte == nsf_pkg::ChCr)) begin
					bytes_d = bytes_inc;
					if (ovf_len) begin
						fail = 1'b1;
					end else if (rx_byte == nsf_pkg::ChCr) begin
						phase_d = nsf_pkg::PhCr;
					end
				end else begin
					fail = 1'b1;
				end
			end
			nsf_pkg::PhCr: begin
				if (rx_byte != nsf_pkg::ChLf) begin
					fail = 1'b1;
				end else begin
					bytes_d = bytes_inc;
					if (ovf_len) begin
						fail = 1'b1;
					end else begin
						done    = 1'b1;
						phase_d = nsf_pkg::PhIdle;
						if (tlen_q == nsf_pkg::TypeChars && chars_q == nsf_pkg::WordGpgga) begin
							kind = nsf_pkg::KindGga;
						end else if (tlen_q == nsf_pkg::TypeChars &&
							chars_q == nsf_pkg::WordGpgsv) begin
							kind = nsf_pkg::KindGsv;
						end
					end
				end
			end
			default: begin
				// Idle, and any phase code without meaning, waits for the start mark.
				if (rx_byte == nsf_pkg::ChDollar) begin
					phase_d  = nsf_pkg::PhType;
					bytes_d  = 8'd1;
					fields_d = 6'd0;
					chars_d  = 40'd0;
					tlen_d   = 3'd0;
				end else begin
					phase_d = nsf_pkg::PhIdle;
				end
			end
		endcase

		if (fail) begin
			errs_d  = errs_q + 32'd1;
			phase_d = nsf_pkg::PhIdle;
		end
		if (done) begin
			sent_d = sent_q + 32'd1;
		end

		res.fire                    = step && (fail || done);
		res.evt.event_kind          = fail ? nsf_pkg::EvError : nsf_pkg::EvDone;
		res.evt.sentence_kind       = fail ? nsf_pkg::KindOther : kind;
		res.evt.field_count         = fields_d;
		res.evt.byte_count          = bytes_d;
		res.evt.sentences_seen      = sent_d;
		res.evt.framing_errors_seen = errs_d;
	end

	// Sentence state registers, updated once per stepped byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= nsf_pkg::PhIdle;
			bytes_q  <= 8'd0;
			fields_q <= 6'd0;
			chars_q  <= 40'd0;
			tlen_q   <= 3'd0;
			sent_q   <= 32'd0;
			errs_q   <= 32'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			bytes_q  <= bytes_d;
			fields_q <= fields_d;
			chars_q  <= chars_d;
			tlen_q   <= tlen_d;
			sent_q   <= sent_d;
			errs_q   <= errs_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/nmea_sentence_framer_unit.sv
// Channel  Direction  Payload
// rx       in         rx_byte (8)
// ev       out        event_kind (1), sentence_kind (2), field_count (6),
//                     byte_count (8), sentences_seen (32), framing_errors_seen (32)
//
// One byte item is taken per cycle unless a held result stalls the input. Its result,
// if any, is registered: the byte sits in the input register, and when it advances the
// result register behind the framing logic is loaded. Bytes that cause no result still pass
// through the input register in order.
// A held result stalls the input register and framing state; rx.ready then follows ev.ready.
// arst_n clears the phase, the sentence counts and both event totals.
`default_nettype none

module nmea_sentence_framer_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	nsf_byte_if.sink   rx,
	nsf_event_if.source ev
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               advance;
	logic               out_valid_q;
	nsf_pkg::nsf_event_t evt_q;
	nsf_pkg::nsf_step_t step_res;

	// The byte in the input register moves on when the result slot is free.
	assign advance  = valid_s1 && (!out_valid_q || ev.ready);
	assign rx.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	nsf_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.res     (step_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_res.fire;
		end else if (ev.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_res.fire) begin
			evt_q <= step_res.evt;
		end
	end

	assign ev.valid               = out_valid_q;
	assign ev.event_kind          = evt_q.event_kind;
	assign ev.sentence_kind       = evt_q.sentence_kind;
	assign ev.field_count         = evt_q.field_count;
	assign ev.byte_count          = evt_q.byte_count;
	assign ev.sentences_seen      = evt_q.sentences_seen;
	assign ev.framing_errors_seen = evt_q.framing_errors_seen;

	// A held result keeps the framing state frozen.
	a_stall_holds_core: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ev.ready |-> !advance)
		else $error("framing state stepped while a result was held");

	// Only completed sentences carry a type code.
	a_error_kind_other: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && ev.event_kind == nsf_pkg::EvError |->
		ev.sentence_kind == nsf_pkg::KindOther)
		else $error("framing error carries a sentence type");

	// Counts never pass their limits.
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid |-> ev.byte_count <= nsf_pkg::MaxLen && ev.field_count <= nsf_pkg::MaxArgs)
		else $error("result count beyond its limit");

	// A completed sentence never reaches the length or argument limit.
	a_done_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		ev.valid && ev.event_kind == nsf_pkg::EvDone |->
		ev.byte_count < nsf_pkg::MaxLen && ev.field_count < nsf_pkg::MaxArgs)
		else $error("completed sentence at an overflow count");

endmodule

`default_nettype wire
